// ----- rtl/mck_pkg.sv -----
package mck_pkg;

   localparam int KeyWords   = 8;
   localparam int Rounds     = 32;
   localparam int HalfWidth  = 32;
   localparam int BlockWidth = 64;
   localparam int KeyIdxW    = $clog2(KeyWords);
   localparam int RoundW     = $clog2(Rounds);

   localparam logic [RoundW-1:0] LAST_ROUND = RoundW'(Rounds - 1);
   // rounds from here on walk the key words downward
   localparam logic [RoundW-1:0] REV_ROUND  = RoundW'(Rounds - KeyWords);

   localparam logic FUNC_GENERATE = 1'b0;
   localparam logic FUNC_LOAD     = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic               load_ctr;       // counter takes the request value
      logic               start;          // halves from counter, counter + 1
      logic               round_en;       // one Feistel round
      logic [KeyIdxW-1:0] key_idx;
      logic               out_load;       // result register takes a word
      logic               out_from_round; // word is this cycle's round output
   } cmd_type;

   typedef logic [3:0] sbox_row_type [16];

   localparam sbox_row_type SBOX [8] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
   };

   // nibble n, counted from the LSB, goes through S-box n
   function automatic logic [HalfWidth-1:0] sbox_sub(input logic [HalfWidth-1:0] x);
      logic [HalfWidth-1:0] r;
      r = '0;
      for (int n = 0; n < 8; n++) begin
         r[4*n +: 4] = SBOX[n][x[4*n +: 4]];
      end
      return r;
   endfunction

endpackage

// ----- rtl/mck_datapath.sv -----
module mck_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mck_pkg::KeyIdxW-1:0]        csr_index,
   input  logic [mck_pkg::HalfWidth-1:0]      csr_wdata,
   input  logic [mck_pkg::BlockWidth-1:0]     req_counter_value,
   input  mck_pkg::cmd_type                   cmd,
   output logic [mck_pkg::BlockWidth-1:0]     rsp_keystream_word
);

   logic [mck_pkg::HalfWidth-1:0]  key_ff [mck_pkg::KeyWords];
   logic [mck_pkg::BlockWidth-1:0] ctr_ff, ctr_in;
   logic [mck_pkg::HalfWidth-1:0]  hi_ff, hi_in;
   logic [mck_pkg::HalfWidth-1:0]  lo_ff, lo_in;
   logic [mck_pkg::BlockWidth-1:0] word_ff, word_in;

   logic [mck_pkg::HalfWidth-1:0]  sum;
   logic [mck_pkg::HalfWidth-1:0]  sub;
   logic [mck_pkg::HalfWidth-1:0]  round_out;

   // shared round unit
   assign sum       = lo_ff + key_ff[cmd.key_idx];
   assign sub       = mck_pkg::sbox_sub(sum);
   assign round_out = hi_ff ^ {sub[20:0], sub[31:21]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mck_pkg::KeyWords; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      ctr_in = ctr_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (cmd.load_ctr) begin
         ctr_in = req_counter_value;
      end else if (cmd.start) begin
         ctr_in = ctr_ff + mck_pkg::BlockWidth'(1);
         hi_in  = ctr_ff[mck_pkg::BlockWidth-1:mck_pkg::HalfWidth];
         lo_in  = ctr_ff[mck_pkg::HalfWidth-1:0];
      end else if (cmd.round_en) begin
         hi_in  = lo_ff;
         lo_in  = round_out;
      end
   end

   // output halves come out swapped
   always_comb begin
      word_in = word_ff;
      if (cmd.out_load) begin
         word_in = cmd.out_from_round ? {round_out, lo_ff} : {lo_ff, hi_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
      end else begin
         ctr_ff <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      word_ff <= word_in;
   end

   assign rsp_keystream_word = word_ff;

endmodule

// ----- rtl/mck_ctrl.sv -----
module mck_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mck_pkg::cmd_type cmd
);

   mck_pkg::state_type            state_ff, state_in;
   logic [mck_pkg::RoundW-1:0]    round_ff, round_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          slot_free;
   logic                          last_round;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign last_round = (round_ff == mck_pkg::LAST_ROUND);

   // next state
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      case (state_ff)
         mck_pkg::ST_IDLE: begin
            if (req_valid && req_func == mck_pkg::FUNC_GENERATE) begin
               state_in = mck_pkg::ST_ROUND;
               round_in = '0;
            end
         end
         mck_pkg::ST_ROUND: begin
            round_in = round_ff + mck_pkg::RoundW'(1);
            if (last_round) begin
               state_in = slot_free ? mck_pkg::ST_IDLE : mck_pkg::ST_HOLD;
            end
         end
         mck_pkg::ST_HOLD: begin
            if (slot_free) begin
               state_in = mck_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mck_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready          = 1'b0;
      cmd                = '0;
      cmd.key_idx        = (round_ff >= mck_pkg::REV_ROUND) ? ~round_ff[mck_pkg::KeyIdxW-1:0]
                                                            : round_ff[mck_pkg::KeyIdxW-1:0];
      case (state_ff)
         mck_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_ctr = req_valid && req_func == mck_pkg::FUNC_LOAD;
            cmd.start    = req_valid && req_func == mck_pkg::FUNC_GENERATE;
         end
         mck_pkg::ST_ROUND: begin
            cmd.round_en       = 1'b1;
            cmd.out_load       = last_round && slot_free;
            cmd.out_from_round = 1'b1;
         end
         mck_pkg::ST_HOLD: begin
            cmd.out_load = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mck_pkg::ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_gen_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == mck_pkg::FUNC_GENERATE
      |=> state_ff == mck_pkg::ST_ROUND && round_ff == '0)
      else $error("generate transfer did not start round 0");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten before transfer");

   a_hold_means_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == mck_pkg::ST_HOLD |-> rsp_valid_ff)
      else $error("holding a result with an empty output slot");

   a_last_round_lands: assert property (@(posedge clock) disable iff (reset)
      state_ff == mck_pkg::ST_ROUND && round_ff == mck_pkg::LAST_ROUND
      |=> rsp_valid_ff || state_ff == mck_pkg::ST_HOLD)
      else $error("finished word neither presented nor held");

endmodule

// ----- rtl/magma_counter_keystream_unit.sv -----
// Magma counter-mode keystream unit.
// Key words 0..7 are written through csr_we/csr_index/csr_wdata, one 32-bit
// word per cycle; the user must write them only while the unit is idle: the unit itself has no guard.
// Request channel (req_valid/req_ready): req_func = 0 asks for the next
// keystream word, req_func = 1 loads req_counter_value into the counter and
// produces no response. Result channel (rsp_valid/rsp_ready) carries
// rsp_keystream_word, the encryption of the counter before it advanced.
// A generate transfer is followed by the 32 rounds through one shared round
// unit; the word is registered after the last round if the output register
// is free. req_ready is high only while idle, so a new request is taken only
// once the previous word is finished; a load leaves the unit idle.
// The result sits in an output register: a new request is taken while it
// waits. If the previous word is still untaken when a new one finishes, the
// unit holds the final round state until the output register frees up.
// Reset clears the key words, the counter and the result valid flag.
module magma_counter_keystream_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mck_pkg::KeyIdxW-1:0]        csr_index,
   input  logic [mck_pkg::HalfWidth-1:0]      csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [mck_pkg::BlockWidth-1:0]     req_counter_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mck_pkg::BlockWidth-1:0]     rsp_keystream_word
);

   mck_pkg::cmd_type cmd;

   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mck_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_counter_value  (req_counter_value),
      .cmd                (cmd),
      .rsp_keystream_word (rsp_keystream_word)
   );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 500000;
   // settle margin that wait_idle adds after the last word
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [mck_pkg::KeyIdxW-1:0]    csr_index;
   logic [mck_pkg::HalfWidth-1:0]  csr_wdata;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_func;
   logic [mck_pkg::BlockWidth-1:0] req_counter_value;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [mck_pkg::BlockWidth-1:0] rsp_keystream_word;

   // shadow of the key registers and the block counter
   logic [mck_pkg::HalfWidth-1:0]  model_key [mck_pkg::KeyWords];
   logic [mck_pkg::BlockWidth-1:0] model_counter;
   logic [mck_pkg::BlockWidth-1:0] keystream_queue [$];
   logic [mck_pkg::BlockWidth-1:0] expected_word;

   bit idle_enable;
   int hold_cycles;
   int rsp_wait;
   int cycle_count;
   int mismatch_count;
   int checked_count;
   int generate_count;
   int load_count;
   int key_write_count;

   magma_counter_keystream_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_counter_value  (req_counter_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_word (rsp_keystream_word)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // S-box rows, entry i at bits [4*i +: 4]
   function automatic logic [63:0] subst_row(input int n);
      case (n)
         0: return 64'h1F307D8E9B5A264C;
         1: return 64'hF0DB74E1C5A93286;
         2: return 64'h069C471EDAF2853B;
         3: return 64'hB9E35A076F4D128C;
         4: return 64'hC24BE390D618A5F7;
         5: return 64'h0E34187BAC296FD5;
         6: return 64'h73AD0B4FC19652E8;
         default: return 64'h2BC96AF43850DE71;
      endcase
   endfunction

   function automatic logic [mck_pkg::HalfWidth-1:0] round_mix(
         input logic [mck_pkg::HalfWidth-1:0] half,
         input logic [mck_pkg::HalfWidth-1:0] key);
      logic [mck_pkg::HalfWidth-1:0] sum;
      logic [mck_pkg::HalfWidth-1:0] sub;
      logic [63:0]                   row;
      sum = half + key;
      for (int n = 0; n < 8; n++) begin
         row = subst_row(n);
         sub[4*n +: 4] = row[{sum[4*n +: 4], 2'b00} +: 4];
      end
      return {sub[20:0], sub[31:21]};
   endfunction

   function automatic logic [mck_pkg::BlockWidth-1:0] magma_cipher(
         input logic [mck_pkg::BlockWidth-1:0] blk);
      logic [mck_pkg::HalfWidth-1:0] hi;
      logic [mck_pkg::HalfWidth-1:0] lo;
      logic [mck_pkg::HalfWidth-1:0] t;
      int                            ki;
      hi = blk[63:32];
      lo = blk[31:0];
      for (int r = 0; r < mck_pkg::Rounds; r++) begin
         ki = (r < mck_pkg::Rounds - mck_pkg::KeyWords) ? (r % mck_pkg::KeyWords)
                                                        : (mck_pkg::Rounds - 1 - r);
         t  = hi ^ round_mix(lo, model_key[ki]);
         hi = lo;
         lo = t;
      end
      return {lo, hi};
   endfunction

   function automatic logic [mck_pkg::HalfWidth-1:0] pick_key_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // one request transfer; called at a falling edge, returns at a falling edge
   task automatic send_request(input logic func,
                               input logic [mck_pkg::BlockWidth-1:0] value);
      int gap;
      gap = idle_enable ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_func          = func;
      req_counter_value = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == mck_pkg::FUNC_LOAD) begin
         model_counter = value;
         load_count++;
      end else begin
         keystream_queue.push_back(magma_cipher(model_counter));
         model_counter = model_counter + 64'd1;
         generate_count++;
      end
      @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [mck_pkg::BlockWidth-1:0] value;
      value = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 3))
            0: value = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            1: value = 64'($urandom_range(0, 15));
            default: ;
         endcase
         send_request(mck_pkg::FUNC_LOAD, value);
      end else begin
         send_request(mck_pkg::FUNC_GENERATE, value);
      end
   endtask

   // key writes only happen with nothing in flight
   task automatic wait_idle();
      req_valid = 1'b0;
      while (keystream_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_key(input int idx, input logic [mck_pkg::HalfWidth-1:0] value);
      csr_we    = 1'b1;
      csr_index = mck_pkg::KeyIdxW'(idx);
      csr_wdata = value;
      @(negedge clock);
      csr_we         = 1'b0;
      model_key[idx] = value;
      key_write_count++;
   endtask

   task automatic write_random_key();
      wait_idle();
      for (int i = 0; i < mck_pkg::KeyWords; i++) write_key(i, pick_key_word());
   endtask

   task automatic test_directed_edges();
      // reset state: zero key, counter at zero
      send_request(mck_pkg::FUNC_GENERATE, '0);
      send_request(mck_pkg::FUNC_GENERATE, '1);
      // counter wrap from all ones
      send_request(mck_pkg::FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(mck_pkg::FUNC_GENERATE, '0);
      send_request(mck_pkg::FUNC_GENERATE, '0);
      // nibble 1 of the first round sum is 12 under the zero key
      send_request(mck_pkg::FUNC_LOAD, 64'h0000_0000_0000_00C0);
      send_request(mck_pkg::FUNC_GENERATE, '0);
      // back-to-back loads, only the last one counts
      send_request(mck_pkg::FUNC_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(mck_pkg::FUNC_LOAD, 64'h5555_5555_5555_5555);
      send_request(mck_pkg::FUNC_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA);
      wait_idle();
      for (int i = 0; i < mck_pkg::KeyWords; i++) write_key(i, '1);
      send_request(mck_pkg::FUNC_GENERATE, '1);
      send_request(mck_pkg::FUNC_LOAD, '0);
      send_request(mck_pkg::FUNC_GENERATE, '1);
      send_request(mck_pkg::FUNC_LOAD, '1);
      send_request(mck_pkg::FUNC_GENERATE, '1);
      send_request(mck_pkg::FUNC_GENERATE, '1);
      wait_idle();
      for (int i = 0; i < mck_pkg::KeyWords; i++) begin
         write_key(i, (i % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555);
      end
      send_request(mck_pkg::FUNC_LOAD, 64'h8000_0000_0000_0000);
      send_request(mck_pkg::FUNC_GENERATE, '0);
      send_request(mck_pkg::FUNC_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(mck_pkg::FUNC_GENERATE, '0);
      send_request(mck_pkg::FUNC_GENERATE, '0);
   endtask

   task automatic test_key_sweep();
      for (int s = 0; s < 4; s++) begin
         write_random_key();
         repeat (20) send_random_item();
      end
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      idle_enable = 1'b0;
      hold_cycles = 600;
      // receiver stalled: the unit fills and stops taking requests
      repeat (12) send_request(mck_pkg::FUNC_GENERATE, {$urandom, $urandom});
      idle_enable = 1'b1;
      // sender pauses until every word is back
      wait_idle();
      repeat (20) send_random_item();
   endtask

   task automatic test_streaming();
      idle_enable = 1'b0;
      repeat (100) send_random_item();
      idle_enable = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int blk = 0; blk < 7; blk++) begin
         write_random_key();
         repeat (245) send_random_item();
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_func          = mck_pkg::FUNC_GENERATE;
      req_counter_value = '0;
      idle_enable       = 1'b1;
      hold_cycles       = 0;
      rsp_wait          = 0;
      mismatch_count    = 0;
      checked_count     = 0;
      generate_count    = 0;
      load_count        = 0;
      key_write_count   = 0;
      model_counter     = '0;
      for (int i = 0; i < mck_pkg::KeyWords; i++) model_key[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_key_sweep();
      test_output_backpressure();
      test_streaming();
      test_random_traffic();

      wait_idle();
      $display("Covered %0d keystream words and %0d counter loads over %0d key writes,",
               generate_count, load_count, key_write_count);
      $display("including counter wrap, all-zero/all-one keys and a long output stall.");
      if (mismatch_count == 0 && keystream_queue.size() == 0) begin
         $display("** magma_counter_keystream_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d words outstanding", mismatch_count,
                  keystream_queue.size());
         $display("** magma_counter_keystream_unit: FAILED **");
      end
      $finish;
   end

   // receiver: random stall per word, plus the long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else if (rsp_wait > 0) begin
            rsp_ready = 1'b0;
            if (rsp_valid) rsp_wait--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (keystream_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected keystream word %h", $realtime, rsp_keystream_word);
            end
         end else begin
            expected_word = keystream_queue.pop_front();
            checked_count++;
            if (rsp_keystream_word !== expected_word) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: keystream_word expected %h got %h", $realtime,
                           expected_word, rsp_keystream_word);
               end
            end
         end
         rsp_wait = idle_enable ? $urandom_range(0, 7) : 0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                  keystream_queue.size());
         $display("** magma_counter_keystream_unit: FAILED **");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
rtl/mck_pkg.sv
rtl/mck_datapath.sv
rtl/mck_ctrl.sv
rtl/magma_counter_keystream_unit.sv
dv/testbench.sv
